@@ hdl/ydd_pkg.sv @@
// Shared types, constants and the exponential table builder for the detection decoder.
`default_nettype none

package ydd_pkg;

   // Sizing constants
   localparam int MAX_GRID_SIDE   = 1024;
   localparam int MAX_CLASSES     = 255;
   localparam int EXP_TABLE_DEPTH = 1024;
   localparam int BOX_VALUES      = 5;
   localparam int BOX_COORDS      = 4;

   // Fixed-point constants: log2(e) in Q16, ln(2) in Q30
   localparam int              LOG2E_Q16 = 94548;
   localparam longint unsigned LN2_Q30   = 64'd744261118;

   // Derived widths
   localparam int POS_W      = $clog2(MAX_CLASSES + BOX_VALUES);
   localparam int IDX_W      = $clog2(MAX_GRID_SIDE);
   localparam int EXP_IDX_W  = $clog2(EXP_TABLE_DEPTH);
   localparam int MULA_W     = IDX_W + 12;
   localparam int MULB_W     = 18;
   localparam int PROD_W     = MULA_W + MULB_W;
   localparam int FSCALE_W   = 26 + EXP_IDX_W + 1;
   localparam int IP_W       = 8;
   localparam int MAG_W      = 40;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_WIDTH      = 3'd0,
      CSR_GRID_HEIGHT     = 3'd1,
      CSR_CLASS_COUNT     = 3'd2,
      CSR_CELL_STRIDE     = 3'd3,
      CSR_SCORE_THRESHOLD = 3'd4
   } csr_index_type;

   // Element positions inside a cell
   localparam logic [POS_W-1:0] POS_CENTER_X   = POS_W'(0);
   localparam logic [POS_W-1:0] POS_CENTER_Y   = POS_W'(1);
   localparam logic [POS_W-1:0] POS_WIDTH      = POS_W'(2);
   localparam logic [POS_W-1:0] POS_HEIGHT     = POS_W'(3);
   localparam logic [POS_W-1:0] POS_OBJECTNESS = POS_W'(4);

   typedef struct packed {
      logic [10:0] grid_width;
      logic [10:0] grid_height;
      logic [7:0]  class_count;
      logic [7:0]  cell_stride;
      logic [10:0] score_threshold;
   } cfg_type;

   // Item leaving the input register
   typedef struct packed {
      logic signed [15:0] value;
      logic [POS_W-1:0]   pos;
      logic [IDX_W-1:0]   idx;
   } s0_type;

   typedef logic [31:0] exp_table_type [EXP_TABLE_DEPTH];

   // 2^(i/DEPTH) in Q30 by a truncated Taylor series of exp(i*ln2/DEPTH)
   function automatic exp_table_type build_exp_table();
      exp_table_type   t;
      longint unsigned z;
      longint unsigned sum;
      longint unsigned term;
      for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
         z    = (64'(i) * LN2_Q30) / EXP_TABLE_DEPTH;
         sum  = 64'd1 << 30;
         term = 64'd1 << 30;
         for (int k = 1; k <= 24; k++) begin
            term = ((term * z) >> 30) / 64'(k);
            sum  = sum + term;
         end
         t[i] = sum[31:0];
      end
      return t;
   endfunction

endpackage

`default_nettype wire

@@ hdl/ydd_if.sv @@
// Valid/ready channel interfaces for tensor values in and detections out.
`default_nettype none

interface ydd_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] value;
   logic               first_of_layer;

   modport source (output valid, output value, output first_of_layer, input ready);
   modport sink   (input valid, input value, input first_of_layer, output ready);
endinterface

interface ydd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] center_x;
   logic signed [15:0] center_y;
   logic [15:0]        box_width;
   logic [15:0]        box_height;
   logic [10:0]        score;
   logic [7:0]         class_index;

   modport source (output valid, output center_x, output center_y, output box_width,
                   output box_height, output score, output class_index, input ready);
   modport sink   (input valid, input center_x, input center_y, input box_width,
                   input box_height, input score, input class_index, output ready);
endinterface

`default_nettype wire

@@ hdl/yolo_detection_decode.sv @@
// Top level of the anchor-free detection decoder.
//
//  channel    direction  handshake          payload
//  req_chan   in         valid/ready        value, first_of_layer
//  rsp_chan   out        valid/ready        center_x, center_y, box_width, box_height,
//                                           score, class_index
//  csr_*      in         write enable only  index, write data (11 bits)
//
// One tensor value is taken per cycle while the result channel does not stall; each
// value passes the input register, shared multiplier stage, exp ROM read, stride
// scaling and result register, in that order.
// Values that emit nothing still flow through the pipeline to keep box order.
// Reset needs no clearing pass. A stalled result stops only the stages
// behind it that are full, so empty stages still take new transfers.
`default_nettype none

module yolo_detection_decode
   import ydd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   ydd_req_if.sink                     req_chan,
   ydd_rsp_if.source                   rsp_chan,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wr_data
);

   cfg_type cfg;
   s0_type  s0;
   logic    s0_valid;
   logic    s1_ready;

   ydd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   ydd_cell_counter u_cell_counter (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cfg      (cfg),
      .s1_ready (s1_ready),
      .s0_valid (s0_valid),
      .s0       (s0)
   );

   ydd_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .s0_valid (s0_valid),
      .s0       (s0),
      .s1_ready (s1_ready),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

@@ hdl/ydd_csr.sv @@
// Configuration registers of the detection decoder.
`default_nettype none

module ydd_csr
   import ydd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wr_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register index
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_WIDTH:      cfg_in.grid_width      = csr_wr_data;
            CSR_GRID_HEIGHT:     cfg_in.grid_height     = csr_wr_data;
            CSR_CLASS_COUNT:     cfg_in.class_count     = csr_wr_data[7:0];
            CSR_CELL_STRIDE:     cfg_in.cell_stride     = csr_wr_data[7:0];
            CSR_SCORE_THRESHOLD: cfg_in.score_threshold = csr_wr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width      <= 11'd80;
         cfg_ff.grid_height     <= 11'd80;
         cfg_ff.class_count     <= 8'd80;
         cfg_ff.cell_stride     <= 8'd8;
         cfg_ff.score_threshold <= 11'd512;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ hdl/ydd_cell_counter.sv @@
// Input register with the element, column and row counters of the grid walk.
`default_nettype none

module ydd_cell_counter
   import ydd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   ydd_req_if.sink      req_chan,
   input  wire cfg_type cfg,
   input  wire logic    s1_ready,
   output logic         s0_valid,
   output s0_type       s0
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] col_ff, col_in;
   logic [IDX_W-1:0] row_ff, row_in;
   logic             s0_valid_ff;
   s0_type           s0_ff;

   logic             s0_ready;
   logic             accept;
   logic [POS_W-1:0] cur_pos;
   logic [IDX_W-1:0] cur_col;
   logic [IDX_W-1:0] cur_row;
   logic [POS_W:0]   pos_inc;
   logic [IDX_W:0]   col_inc;
   logic [IDX_W:0]   row_inc;
   logic [15:0]      classes;
   logic             cell_end;
   logic             col_wrap;
   logic             row_wrap;

   assign s0_ready       = !s0_valid_ff || s1_ready;
   assign req_chan.ready = s0_ready;
   assign accept         = req_chan.valid && s0_ready;

   // Restart the walk on the first value of a layer
   always_comb begin
      cur_pos = req_chan.first_of_layer ? '0 : pos_ff;
      cur_col = req_chan.first_of_layer ? '0 : col_ff;
      cur_row = req_chan.first_of_layer ? '0 : row_ff;
      classes = (16'(cfg.class_count) > 16'(MAX_CLASSES)) ? 16'(MAX_CLASSES)
                                                           : 16'(cfg.class_count);
      pos_inc  = (POS_W+1)'(cur_pos) + (POS_W+1)'(1);
      col_inc  = (IDX_W+1)'(cur_col) + (IDX_W+1)'(1);
      row_inc  = (IDX_W+1)'(cur_row) + (IDX_W+1)'(1);
      cell_end = 16'(pos_inc) >= (classes + 16'(BOX_VALUES));
      col_wrap = (16'(col_inc) >= 16'(cfg.grid_width)) ||
                 (16'(col_inc) >= 16'(MAX_GRID_SIDE));
      row_wrap = (16'(row_inc) >= 16'(cfg.grid_height)) ||
                 (16'(row_inc) >= 16'(MAX_GRID_SIDE));

      pos_in = pos_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         pos_in = pos_inc[POS_W-1:0];
         col_in = cur_col;
         row_in = cur_row;
         if (cell_end) begin
            pos_in = '0;
            col_in = col_inc[IDX_W-1:0];
            if (col_wrap) begin
               col_in = '0;
               row_in = row_wrap ? '0 : row_inc[IDX_W-1:0];
            end
         end
      end
   end

   // Advance the counters
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Hold the accepted item until the next stage takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_ff.value <= req_chan.value;
         s0_ff.pos   <= cur_pos;
         s0_ff.idx   <= (cur_pos == POS_CENTER_Y) ? cur_row : cur_col;
      end
   end

   assign s0_valid = s0_valid_ff;
   assign s0       = s0_ff;

endmodule

`default_nettype wire

@@ hdl/ydd_exp_rom.sv @@
// Registered-read ROM of 2^(i/DEPTH) in Q30.
`default_nettype none

module ydd_exp_rom
   import ydd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 enable,
   input  wire logic [EXP_IDX_W-1:0] addr,
   output logic [31:0]               data
);

   localparam exp_table_type EXP_TABLE = build_exp_table();

   logic [31:0] data_ff;

   // Read on enable, hold otherwise
   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= EXP_TABLE[addr];
      end
   end

   assign data = data_ff;

endmodule

`default_nettype wire

@@ hdl/ydd_datapath.sv @@
// Decode pipeline: shared multiplier, rounding, table scaling and the result register.
`default_nettype none

module ydd_datapath
   import ydd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    s0_valid,
   input  wire s0_type  s0,
   output logic         s1_ready,
   ydd_rsp_if.source    rsp_chan
);

   typedef struct packed {
      logic signed [PROD_W-1:0] prod;
      logic [POS_W-1:0]         pos;
      logic                     cand;
   } s1_type;

   typedef struct packed {
      logic [15:0]            word;
      logic signed [IP_W-1:0] ip;
      logic [POS_W-1:0]       pos;
      logic                   hit;
   } s2_type;

   typedef struct packed {
      logic [15:0]            word;
      logic [MAG_W-1:0]       mag;
      logic signed [IP_W-1:0] ip;
      logic [POS_W-1:0]       pos;
      logic                   hit;
   } s3_type;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   logic   s1_valid_ff, s2_valid_ff, s3_valid_ff;

   logic signed [15:0] objectness_ff;
   logic               passed_ff;
   logic [15:0]        box_ff [BOX_COORDS];

   logic               rsp_valid_ff;
   logic signed [15:0] center_x_ff, center_y_ff;
   logic [15:0]        box_width_ff, box_height_ff;
   logic [10:0]        score_ff;
   logic [7:0]         class_index_ff;

   logic out_adv, s3_ready, s2_ready;

   logic signed [MULA_W-1:0] mul_a;
   logic signed [MULB_W-1:0] mul_b;

   logic signed [PROD_W:0]    csum;
   logic signed [PROD_W:0]    cshift;
   logic [PROD_W-15:0]        chigh;
   logic [15:0]               center;
   logic [25:0]               frac;
   logic [FSCALE_W-1:0]       fscaled;
   logic [EXP_IDX_W-1:0]      rom_addr;
   logic [31:0]               rom_data;
   logic [20:0]               thr_scaled;
   logic signed [PROD_W-11:0] pshift;
   logic [10:0]               sc;
   logic                      is_class;

   logic signed [IP_W-1:0] shift_s;
   logic [MAG_W:0]         rsum;
   logic [MAG_W:0]         rshift;
   logic [15:0]            size;

   // Stall chain: each stage moves when it is empty or the next one moves
   assign out_adv  = !rsp_valid_ff || rsp_chan.ready;
   assign s3_ready = !s3_valid_ff || out_adv;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= s0_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   // Stage 1: pick multiplier operands by element position
   always_comb begin
      mul_a = MULA_W'(s0.value);
      mul_b = MULB_W'(objectness_ff);
      case (s0.pos) inside
         POS_CENTER_X, POS_CENTER_Y: begin
            mul_a = MULA_W'(s0.value) + $signed({2'b00, s0.idx, 10'b0});
            mul_b = $signed({10'b0, cfg.cell_stride});
         end
         POS_WIDTH, POS_HEIGHT: begin
            mul_b = $signed(MULB_W'(LOG2E_Q16));
         end
         default: begin
            mul_b = MULB_W'(objectness_ff);
         end
      endcase
      s1_in.prod = PROD_W'(mul_a) * PROD_W'(mul_b);
      s1_in.pos  = s0.pos;
      s1_in.cand = passed_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ff <= s1_in;
      end
   end

   // Capture objectness and the cell pass flag
   always_ff @(posedge clock) begin
      if (reset) begin
         objectness_ff <= '0;
         passed_ff     <= 1'b0;
      end else if (s0_valid && s1_ready && s0.pos == POS_OBJECTNESS) begin
         objectness_ff <= s0.value;
         passed_ff     <= $signed({{2{s0.value[15]}}, s0.value}) >=
                          $signed({7'b0, cfg.score_threshold});
      end
   end

   // Stage 2: round centers, split log2, test class score
   always_comb begin
      csum   = $signed({s1_ff.prod[PROD_W-1], s1_ff.prod}) + $signed((PROD_W+1)'(32));
      cshift = csum >>> 6;
      chigh  = cshift[PROD_W:15];
      if ((&chigh) || !(|chigh)) begin
         center = cshift[15:0];
      end else begin
         center = chigh[PROD_W-15] ? 16'h8000 : 16'h7fff;
      end

      frac     = s1_ff.prod[25:0];
      fscaled  = FSCALE_W'(frac) * FSCALE_W'(EXP_TABLE_DEPTH);
      rom_addr = fscaled[26 +: EXP_IDX_W];

      thr_scaled = {cfg.score_threshold, 10'b0};
      pshift     = s1_ff.prod[PROD_W-1:10];
      sc         = (pshift > $signed((PROD_W-10)'(1024))) ? 11'd1024 : pshift[10:0];
      is_class   = 16'(s1_ff.pos) >= 16'(BOX_VALUES);

      s2_in.ip  = s1_ff.prod[26 +: IP_W];
      s2_in.pos = s1_ff.pos;
      s2_in.hit = s1_ff.cand && is_class &&
                  (s1_ff.prod >= $signed({{(PROD_W-21){1'b0}}, thr_scaled}));
      case (s1_ff.pos) inside
         POS_CENTER_X, POS_CENTER_Y: s2_in.word = center;
         default:                    s2_in.word = {5'b0, sc};
      endcase
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
   end

   ydd_exp_rom u_exp_rom (
      .clock  (clock),
      .enable (s2_ready),
      .addr   (rom_addr),
      .data   (rom_data)
   );

   // Stage 3: scale the table value by the stride
   always_comb begin
      s3_in.word = s2_ff.word;
      s3_in.mag  = MAG_W'(rom_data) * MAG_W'(cfg.cell_stride);
      s3_in.ip   = s2_ff.ip;
      s3_in.pos  = s2_ff.pos;
      s3_in.hit  = s2_ff.hit;
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_ff <= s3_in;
      end
   end

   // Final stage: shift by the integer part of log2, round and saturate
   always_comb begin
      shift_s = $signed(IP_W'(26)) - s3_ff.ip;
      rsum    = {1'b0, s3_ff.mag} + ((MAG_W+1)'(1) << (shift_s[5:0] - 6'd1));
      rshift  = rsum >> shift_s[5:0];
      if (s3_ff.mag == '0) begin
         size = 16'd0;
      end else if (s3_ff.ip >= $signed(IP_W'(12))) begin
         size = 16'hffff;
      end else if (shift_s > $signed(IP_W'(40))) begin
         size = 16'd0;
      end else begin
         size = (|rshift[MAG_W:16]) ? 16'hffff : rshift[15:0];
      end
   end

   // Update the decoded box in element order
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BOX_COORDS; i++) begin
            box_ff[i] <= '0;
         end
      end else if (s3_valid_ff && out_adv) begin
         case (s3_ff.pos)
            POS_CENTER_X: box_ff[0] <= s3_ff.word;
            POS_CENTER_Y: box_ff[1] <= s3_ff.word;
            POS_WIDTH:    box_ff[2] <= size;
            POS_HEIGHT:   box_ff[3] <= size;
            default:      ;
         endcase
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= s3_valid_ff && s3_ff.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && s3_valid_ff && s3_ff.hit) begin
         center_x_ff    <= $signed(box_ff[0]);
         center_y_ff    <= $signed(box_ff[1]);
         box_width_ff   <= box_ff[2];
         box_height_ff  <= box_ff[3];
         score_ff       <= s3_ff.word[10:0];
         class_index_ff <= 8'(s3_ff.pos - POS_W'(BOX_VALUES));
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.center_x    = center_x_ff;
   assign rsp_chan.center_y    = center_y_ff;
   assign rsp_chan.box_width   = box_width_ff;
   assign rsp_chan.box_height  = box_height_ff;
   assign rsp_chan.score       = score_ff;
   assign rsp_chan.class_index = class_index_ff;

endmodule

`default_nettype wire
